### src/kmst_pkg.sv
// Shared constants and types for the spanning tree weight block.
`timescale 1ns / 1ps
package kmst_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int VIDX_BITS = $clog2(MAX_VERTICES);
  localparam int EIDX_BITS = $clog2(MAX_EDGES);
  localparam int ECNT_BITS = EIDX_BITS + 1;
  localparam int TOTAL_BITS = 22;
  localparam int COUNT_BITS = 6;
  localparam int VCNT_BITS = 7;
  localparam int RANK_BITS = 3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

  typedef struct packed {
    logic [VIDX_BITS-1:0] from_v;
    logic [VIDX_BITS-1:0] to_v;
    logic signed [WEIGHT_BITS-1:0] weight;
  } edge_t;
endpackage

### src/kmst_sort.sv
// Edge store with in-place insertion sort, ascending by signed weight.
`timescale 1ns / 1ps
module kmst_sort (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [kmst_pkg::EIDX_BITS-1:0] wr_addr,
  input  kmst_pkg::edge_t wr_edge,
  input  logic start,
  input  logic [kmst_pkg::ECNT_BITS-1:0] count,
  output logic done,
  input  logic rd_en,
  input  logic [kmst_pkg::EIDX_BITS-1:0] rd_addr,
  output kmst_pkg::edge_t rd_edge
);
  import kmst_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_LOADKEY, S_WAITKEY, S_READ, S_CMP, S_PUT,
    S_DONE} state_t;
  state_t state;
  edge_t mem [MAX_EDGES];
  edge_t key, q;
  logic [ECNT_BITS-1:0] i, j;
  logic m_we;
  logic [EIDX_BITS-1:0] m_wa, m_ra;
  edge_t m_wd;

  always_comb begin
    m_we = wr_en;
    m_wa = wr_addr;
    m_wd = wr_edge;
    m_ra = rd_addr;
    case (state)
      S_LOADKEY: m_ra = i[EIDX_BITS-1:0];
      S_READ: m_ra = EIDX_BITS'(j - 1'b1);
      S_CMP: begin
        m_we = 1'b1;
        m_wa = j[EIDX_BITS-1:0];
        m_wd = ($signed(q.weight) > $signed(key.weight)) ? q : key;
      end
      S_PUT: begin
        // key shifted all the way down to the front
        m_we = 1'b1;
        m_wa = j[EIDX_BITS-1:0];
        m_wd = key;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (m_we) mem[m_wa] <= m_wd;
    if (rd_en || state == S_LOADKEY || state == S_READ) q <= mem[m_ra];
  end
  assign rd_edge = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          i <= ECNT_BITS'(1);
          state <= (count > ECNT_BITS'(1)) ? S_LOADKEY : S_DONE;
        end
        S_LOADKEY: state <= S_WAITKEY;
        S_WAITKEY: begin
          key <= q;
          j <= i;
          state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if ($signed(q.weight) > $signed(key.weight)) begin
            j <= j - 1'b1;
            state <= (j > ECNT_BITS'(1)) ? S_READ : S_PUT;
          end else if (i + 1'b1 < count) begin
            i <= i + 1'b1;
            state <= S_LOADKEY;
          end else state <= S_DONE;
        end
        S_PUT: begin
          if (i + 1'b1 < count) begin
            i <= i + 1'b1;
            state <= S_LOADKEY;
          end else state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> state == S_IDLE)
    else $error("sort done not followed by idle");
  assert property (@(posedge clk) disable iff (rst) state == S_CMP |-> j != '0)
    else $error("sort pointer at zero in compare");
  assert property (@(posedge clk) disable iff (rst) state == S_CMP |-> i < count)
    else $error("sort index past count");
endmodule

### src/kmst_forest.sv
// Union-find walk over sorted edges, with path compression and union by rank.
`timescale 1ns / 1ps
module kmst_forest (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [kmst_pkg::ECNT_BITS-1:0] count,
  input  logic [kmst_pkg::VCNT_BITS-1:0] vertex_count,
  output logic rd_en,
  output logic [kmst_pkg::EIDX_BITS-1:0] rd_addr,
  input  kmst_pkg::edge_t rd_edge,
  output logic done,
  output logic signed [kmst_pkg::TOTAL_BITS-1:0] total,
  output logic [kmst_pkg::COUNT_BITS-1:0] tree_count,
  output logic range_err
);
  import kmst_pkg::*;
  typedef enum logic [3:0] {F_IDLE, F_CLEAR, F_FETCH, F_WAIT, F_CHECK,
    F_UP, F_COMP, F_JOIN, F_DONE} state_t;
  state_t state;
  logic [VIDX_BITS-1:0] parent [MAX_VERTICES];
  logic [RANK_BITS-1:0] rank [MAX_VERTICES];
  logic [VIDX_BITS:0] clr;
  logic [ECNT_BITS-1:0] ei;
  edge_t e;
  logic [VIDX_BITS-1:0] cur, root, ra, pdat;
  logic [RANK_BITS-1:0] rka, rkb;
  logic side;
  logic [VCNT_BITS-1:0] nv;
  logic signed [TOTAL_BITS:0] sum;
  localparam logic signed [TOTAL_BITS:0] TMAX = (TOTAL_BITS+1)'((1 << (TOTAL_BITS-1)) - 1);
  localparam logic signed [TOTAL_BITS:0] TMIN = -(TOTAL_BITS+1)'(1 << (TOTAL_BITS-1));

  assign nv = (vertex_count > VCNT_BITS'(MAX_VERTICES)) ? VCNT_BITS'(MAX_VERTICES)
                                                      : vertex_count;
  assign rd_en = (state == F_FETCH);
  assign rd_addr = ei[EIDX_BITS-1:0];
  assign sum = (TOTAL_BITS+1)'($signed(total)) + (TOTAL_BITS+1)'($signed(e.weight));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: if (start) begin
          clr <= '0;
          total <= '0;
          tree_count <= '0;
          range_err <= 1'b0;
          ei <= '0;
          state <= F_CLEAR;
        end
        F_CLEAR: begin
          parent[clr[VIDX_BITS-1:0]] <= clr[VIDX_BITS-1:0];
          rank[clr[VIDX_BITS-1:0]] <= '0;
          clr <= clr + 1'b1;
          if (clr == (VIDX_BITS+1)'(MAX_VERTICES - 1)) state <= F_FETCH;
        end
        F_FETCH: state <= (ei < count) ? F_WAIT : F_DONE;
        F_WAIT: state <= F_CHECK;
        F_CHECK: begin
          e <= rd_edge;
          if (VCNT_BITS'(rd_edge.from_v) >= nv || VCNT_BITS'(rd_edge.to_v) >= nv) begin
            range_err <= 1'b1;
            ei <= ei + 1'b1;
            state <= F_FETCH;
          end else begin
            cur <= rd_edge.from_v;
            pdat <= parent[rd_edge.from_v];
            side <= 1'b0;
            state <= F_UP;
          end
        end
        F_UP: begin
          // climb to the root; pdat holds parent of cur
          if (pdat == cur) begin
            root <= cur;
            cur <= side ? e.to_v : e.from_v;
            pdat <= parent[side ? e.to_v : e.from_v];
            state <= F_COMP;
          end else begin
            cur <= pdat;
            pdat <= parent[pdat];
          end
        end
        F_COMP: begin
          // second pass: point every node on the path at the root
          if (cur == root) begin
            if (!side) begin
              ra <= root;
              side <= 1'b1;
              cur <= e.to_v;
              pdat <= parent[e.to_v];
              state <= F_UP;
            end else begin
              rka <= rank[ra];
              rkb <= rank[root];
              state <= F_JOIN;
            end
          end else begin
            parent[cur] <= root;
            cur <= pdat;
            pdat <= parent[pdat];
          end
        end
        F_JOIN: begin
          if (ra != root) begin
            if (rka < rkb) parent[ra] <= root;
            else begin
              parent[root] <= ra;
              if (rka == rkb && rka != '1) rank[ra] <= rka + 1'b1;
            end
            total <= (sum > TMAX) ? TOTAL_BITS'(TMAX) :
                     (sum < TMIN) ? TOTAL_BITS'(TMIN) : sum[TOTAL_BITS-1:0];
            tree_count <= tree_count + 1'b1;
          end
          ei <= ei + 1'b1;
          state <= F_FETCH;
        end
        F_DONE: begin
          done <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> state == F_IDLE)
    else $error("forest done not followed by idle");
  assert property (@(posedge clk) disable iff (rst) state == F_JOIN |-> side)
    else $error("join before both roots found");
  assert property (@(posedge clk) disable iff (rst) state == F_CHECK |-> ei < count)
    else $error("edge index past count");
endmodule

### src/kruskal_mst_weight_top.sv
// Top level of the spanning tree weight block: edge intake, config and result.
`timescale 1ns / 1ps
// Minimum spanning forest weight (Kruskal, union-find).
// Input channel: one word per edge (edge_from, edge_to, edge_weight,
// last_edge) under in_valid/in_ready. Every accepted word, the last one
// too, loads into a 256-entry edge store; extra edges are dropped
// and flagged.
// The word with last_edge set starts the run: an insertion sort over the
// store (one memory compare at a time), then a clear of all 64 parent
// and rank entries, then a union-find walk that climbs to both roots
// with path compression for each edge and joins them by rank; an edge
// out of range is flagged and skipped. The shared edge memory port and
// the single registered parent-store read per cycle set the pace.
// Input ready is low from the last word until the result is taken.
// Output channel: total_weight, tree_edge_count, status under
// out_valid/out_ready; the result register holds while out_ready is low.
// Config: APB write to address 0 sets vertex_count (reset 64).
// Reset (rst, synchronous) empties the edge set and drops any run.
module kruskal_mst_weight_top (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic [5:0] edge_from,
  input  logic [5:0] edge_to,
  input  logic signed [15:0] edge_weight,
  input  logic last_edge,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [21:0] total_weight,
  output logic [5:0] tree_edge_count,
  output logic [1:0] status
);
  import kmst_pkg::*;
  typedef enum logic [1:0] {T_LOAD, T_SORT, T_WALK, T_OUT} state_t;
  state_t state;
  logic [VCNT_BITS-1:0] vertex_count;
  logic [ECNT_BITS-1:0] edge_total;
  logic drop_err;
  logic accept, store_en, sort_start, sort_done, walk_start, walk_done;
  logic rd_en, range_err;
  logic sort_busy;
  logic [EIDX_BITS-1:0] rd_addr;
  edge_t wr_edge, rd_edge;
  logic signed [TOTAL_BITS-1:0] total;
  logic [COUNT_BITS-1:0] tcount;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_VERTEX_COUNT) ? 32'(vertex_count) : 32'd0;
  assign in_ready = (state == T_LOAD);
  assign accept = in_valid && in_ready;
  assign store_en = accept && (edge_total < ECNT_BITS'(MAX_EDGES));
  assign wr_edge = '{from_v: edge_from, to_v: edge_to, weight: edge_weight};
  assign sort_start = accept && last_edge;
  assign walk_start = sort_done;
  assign out_valid = (state == T_OUT);

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= VCNT_BITS'(MAX_VERTICES);
    else if (psel && penable && pwrite && paddr == REG_VERTEX_COUNT)
      vertex_count <= pwdata[VCNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_LOAD;
      edge_total <= '0;
      drop_err <= 1'b0;
    end else begin
      case (state)
        T_LOAD: if (accept) begin
          if (store_en) edge_total <= edge_total + 1'b1;
          else drop_err <= 1'b1;
          if (last_edge) state <= T_SORT;
        end
        T_SORT: if (sort_done) state <= T_WALK;
        T_WALK: if (walk_done) begin
          total_weight <= total;
          tree_edge_count <= tcount;
          status <= range_err ? ST_RANGE : (drop_err ? ST_DROP : ST_OK);
          state <= T_OUT;
        end
        T_OUT: if (out_ready) begin
          edge_total <= '0;
          drop_err <= 1'b0;
          state <= T_LOAD;
        end
        default: state <= T_LOAD;
      endcase
    end
  end

  // sort_start sees the count before the final word lands, so the sort
  // is started from the T_SORT state instead, once edge_total is updated
  kmst_sort u_sort (
    .clk, .rst,
    .wr_en(store_en), .wr_addr(edge_total[EIDX_BITS-1:0]), .wr_edge,
    .start(state == T_SORT && !sort_done && !sort_busy), .count(edge_total),
    .done(sort_done), .rd_en, .rd_addr, .rd_edge
  );

  always_ff @(posedge clk) begin
    if (rst) sort_busy <= 1'b0;
    else if (state == T_SORT && !sort_busy) sort_busy <= 1'b1;
    else if (sort_done) sort_busy <= 1'b0;
  end

  kmst_forest u_forest (
    .clk, .rst, .start(walk_start), .count(edge_total), .vertex_count,
    .rd_en, .rd_addr, .rd_edge, .done(walk_done), .total, .tree_count(tcount),
    .range_err
  );

  assert property (@(posedge clk) disable iff (rst) sort_start |=> !in_ready)
    else $error("input taken after last word");
  assert property (@(posedge clk) disable iff (rst) walk_done |=> out_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst) edge_total <= ECNT_BITS'(MAX_EDGES))
    else $error("edge count over capacity");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> status != 2'd3)
    else $error("bad status code");
endmodule
